[src/cmfs_pkg.sv]
// Shared types and constants for the cube map face select / UV pipeline.
// No dependencies; every other file uses this package by scoped names.
package cmfs_pkg;

	// face width and codes: +x, -x, +y, -y, +z, -z
	localparam int FACE_W = 3;

	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	// per-word control that rides along the pipeline
	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic              neg_u;     // subtract the half ratio from 0.5 for u
		logic              neg_v;     // same for v
		logic              vec_valid; // 0 for the all-zero vector
	} ctl_t;

endpackage

[src/cmfs_select.sv]
// First pipeline stage: magnitudes, major axis and face pick, divider setup.
// Depends on cmfs_pkg.
module cmfs_select #(
	parameter int COMPONENT_BITS = 16,
	parameter int MAG_W = COMPONENT_BITS,
	parameter int REM_W = COMPONENT_BITS + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic signed [COMPONENT_BITS-1:0] dir_x,
	input  logic signed [COMPONENT_BITS-1:0] dir_y,
	input  logic signed [COMPONENT_BITS-1:0] dir_z,
	output logic                             valid_s1,
	output cmfs_pkg::ctl_t                   ctl_s1,
	output logic [MAG_W-1:0]                 div_s1,
	output logic [REM_W-1:0]                 rem_u_s1,
	output logic [REM_W-1:0]                 rem_v_s1
);

	logic              sx, sy, sz;
	logic [MAG_W-1:0]  ax, ay, az;
	logic              x_major, y_major, all_zero;
	cmfs_pkg::ctl_t    ctl_d;
	logic [MAG_W-1:0]  div_d, minor_u, minor_v;

	// magnitudes; the most negative value maps to 2^(C-1), which still fits
	assign sx = dir_x[COMPONENT_BITS-1];
	assign sy = dir_y[COMPONENT_BITS-1];
	assign sz = dir_z[COMPONENT_BITS-1];
	assign ax = sx ? (~MAG_W'(dir_x) + MAG_W'(1)) : MAG_W'(dir_x);
	assign ay = sy ? (~MAG_W'(dir_y) + MAG_W'(1)) : MAG_W'(dir_y);
	assign az = sz ? (~MAG_W'(dir_z) + MAG_W'(1)) : MAG_W'(dir_z);

	// ties go to x, then y
	assign x_major  = (ax >= ay) && (ax >= az);
	assign y_major  = (ay >= az);
	assign all_zero = (ax == '0) && (ay == '0) && (az == '0);

	// face, divisor, minor components and the sign of each half ratio
	always_comb begin
		ctl_d.vec_valid = 1'b1;
		if (all_zero) begin
			// zero vector: -x face, both coordinates at 0.5
			ctl_d.face      = cmfs_pkg::FACE_NX;
			ctl_d.neg_u     = 1'b0;
			ctl_d.neg_v     = 1'b0;
			ctl_d.vec_valid = 1'b0;
			div_d           = MAG_W'(1);
			minor_u         = '0;
			minor_v         = '0;
		end else if (x_major) begin
			ctl_d.face  = sx ? cmfs_pkg::FACE_NX : cmfs_pkg::FACE_PX;
			ctl_d.neg_u = sz ^ sx;
			ctl_d.neg_v = sy ^ sx ^ ~sx;
			div_d       = ax;
			minor_u     = az;
			minor_v     = ay;
		end else if (y_major) begin
			ctl_d.face  = sy ? cmfs_pkg::FACE_NY : cmfs_pkg::FACE_PY;
			ctl_d.neg_u = sx ^ sy ^ ~sy;
			ctl_d.neg_v = sz ^ sy;
			div_d       = ay;
			minor_u     = ax;
			minor_v     = az;
		end else begin
			ctl_d.face  = sz ? cmfs_pkg::FACE_NZ : cmfs_pkg::FACE_PZ;
			ctl_d.neg_u = ~(sx ^ sz);
			ctl_d.neg_v = sy ^ sz ^ ~sz;
			div_d       = az;
			minor_u     = ax;
			minor_v     = ay;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= ctl_d;
			div_s1   <= div_d;
			rem_u_s1 <= REM_W'(minor_u);
			rem_v_s1 <= REM_W'(minor_v);
		end
	end

endmodule

[src/cmfs_div_step.sv]
// One restoring-division stage: one quotient bit for u and one for v per word.
// Stages are chained in the top level. Depends on cmfs_pkg.
module cmfs_div_step #(
	parameter int MAG_W = 16,
	parameter int REM_W = MAG_W + 1,
	parameter int Q_W   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  cmfs_pkg::ctl_t   in_ctl,
	input  logic [MAG_W-1:0] in_div,
	input  logic [REM_W-1:0] in_rem_u,
	input  logic [REM_W-1:0] in_rem_v,
	input  logic [Q_W-1:0]   in_q_u,
	input  logic [Q_W-1:0]   in_q_v,
	output logic             valid_s2,
	output cmfs_pkg::ctl_t   ctl_s2,
	output logic [MAG_W-1:0] div_s2,
	output logic [REM_W-1:0] rem_u_s2,
	output logic [REM_W-1:0] rem_v_s2,
	output logic [Q_W-1:0]   q_u_s2,
	output logic [Q_W-1:0]   q_v_s2
);

	logic [REM_W-1:0] div_ext;
	logic             bit_u, bit_v;
	logic [REM_W-1:0] diff_u, diff_v;

	// compare and subtract; the remainder stays below the divisor
	assign div_ext = REM_W'(in_div);
	assign bit_u   = (in_rem_u >= div_ext);
	assign bit_v   = (in_rem_v >= div_ext);
	assign diff_u  = bit_u ? (in_rem_u - div_ext) : in_rem_u;
	assign diff_v  = bit_v ? (in_rem_v - div_ext) : in_rem_v;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= in_valid;
		end
	end

	// stage payload: remainder doubled for the next bit, quotient shifted in
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2   <= in_ctl;
			div_s2   <= in_div;
			rem_u_s2 <= {diff_u[REM_W-2:0], 1'b0};
			rem_v_s2 <= {diff_v[REM_W-2:0], 1'b0};
			q_u_s2   <= {in_q_u[Q_W-2:0], bit_u};
			q_v_s2   <= {in_q_v[Q_W-2:0], bit_v};
		end
	end

endmodule

[src/cmfs_finish.sv]
// Last stage: applies the sign of each half ratio around 0.5 into the output
// register. Depends on cmfs_pkg.
module cmfs_finish #(
	parameter int UV_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  cmfs_pkg::ctl_t                    in_ctl,
	input  logic [UV_FRAC_BITS-1:0]           in_q_u,
	input  logic [UV_FRAC_BITS-1:0]           in_q_v,
	output logic                              valid_s3,
	output logic [cmfs_pkg::FACE_W-1:0]       face_s3,
	output logic [UV_FRAC_BITS:0]             tex_u_s3,
	output logic [UV_FRAC_BITS:0]             tex_v_s3,
	output logic                              vec_valid_s3
);

	localparam int UV_W = UV_FRAC_BITS + 1;
	localparam logic [UV_W-1:0] HALF = UV_W'(1) << (UV_FRAC_BITS - 1);

	logic [UV_W-1:0] q_u, q_v, u_d, v_d;

	// the half ratio never exceeds 0.5, so no clamp is needed
	assign q_u = UV_W'(in_q_u);
	assign q_v = UV_W'(in_q_v);
	assign u_d = in_ctl.neg_u ? (HALF - q_u) : (HALF + q_u);
	assign v_d = in_ctl.neg_v ? (HALF - q_v) : (HALF + q_v);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			face_s3      <= in_ctl.face;
			tex_u_s3     <= u_d;
			tex_v_s3     <= v_d;
			vec_valid_s3 <= in_ctl.vec_valid;
		end
	end

endmodule

[src/cube_map_face_select_uv.sv]
// Cube map face select with face coordinates. One direction vector per cycle
// goes in while the output is not stalled; each word passes one select stage,
// one restoring-division stage per quotient bit of the minor/major ratio, and
// one output stage. Empty stages close up under a stall, so the input stays
// ready while any stage is free. u and v are unsigned Q1.UV_FRAC_BITS; the zero
// vector gives face -x, u = v = 0.5 and tuser low.
// Depends on cmfs_pkg, cmfs_select, cmfs_div_step and cmfs_finish.
module cube_map_face_select_uv #(
	parameter int COMPONENT_BITS = 16,
	parameter int UV_FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata from bit 0: dir_x, dir_y, dir_z (COMPONENT_BITS each), zero fill
	input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata from bit 0: face (3), tex_u, tex_v (UV_FRAC_BITS+1 each), zero fill
	output logic [((cmfs_pkg::FACE_W+2*UV_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
	// m_tuser: vector_valid
	output logic [0:0]   m_tuser
);

	localparam int UV_W   = UV_FRAC_BITS + 1;
	localparam int OUT_W  = ((cmfs_pkg::FACE_W+2*UV_W+7)/8)*8;
	localparam int MAG_W  = COMPONENT_BITS;
	localparam int REM_W  = COMPONENT_BITS + 1;
	localparam int Q_W    = UV_FRAC_BITS;
	localparam int NSTG   = UV_FRAC_BITS + 2;
	localparam logic [UV_W-1:0] HALF = UV_W'(1) << (UV_FRAC_BITS - 1);
	localparam logic [UV_W-1:0] ONE  = UV_W'(1) << UV_FRAC_BITS;

	// stage 0 is select, 1..Q_W are division steps, Q_W+1 is the output
	logic                 stg_valid [NSTG];
	logic                 stg_adv   [NSTG];
	cmfs_pkg::ctl_t       stg_ctl   [Q_W+1];
	logic [MAG_W-1:0]     stg_div   [Q_W+1];
	logic [REM_W-1:0]     stg_rem_u [Q_W+1];
	logic [REM_W-1:0]     stg_rem_v [Q_W+1];
	logic [Q_W-1:0]       stg_q_u   [Q_W+1];
	logic [Q_W-1:0]       stg_q_v   [Q_W+1];

	logic [cmfs_pkg::FACE_W-1:0] face;
	logic [UV_W-1:0]             tex_u, tex_v;
	logic                        vector_valid;

	// a stage loads when it is empty or its word moves on
	assign stg_adv[NSTG-1] = !stg_valid[NSTG-1] || m_tready;
	for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
		assign stg_adv[i] = !stg_valid[i] || stg_adv[i+1];
	end
	assign s_tready = stg_adv[0];

	// select stage
	cmfs_select #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.MAG_W(MAG_W),
		.REM_W(REM_W)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (stg_adv[0]),
		.in_valid (s_tvalid),
		.dir_x    (s_tdata[COMPONENT_BITS-1:0]),
		.dir_y    (s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
		.dir_z    (s_tdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS]),
		.valid_s1 (stg_valid[0]),
		.ctl_s1   (stg_ctl[0]),
		.div_s1   (stg_div[0]),
		.rem_u_s1 (stg_rem_u[0]),
		.rem_v_s1 (stg_rem_v[0])
	);
	assign stg_q_u[0] = '0;
	assign stg_q_v[0] = '0;

	// division chain, most significant quotient bit first
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		cmfs_div_step #(
			.MAG_W(MAG_W),
			.REM_W(REM_W),
			.Q_W(Q_W)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (stg_adv[k+1]),
			.in_valid (stg_valid[k]),
			.in_ctl   (stg_ctl[k]),
			.in_div   (stg_div[k]),
			.in_rem_u (stg_rem_u[k]),
			.in_rem_v (stg_rem_v[k]),
			.in_q_u   (stg_q_u[k]),
			.in_q_v   (stg_q_v[k]),
			.valid_s2 (stg_valid[k+1]),
			.ctl_s2   (stg_ctl[k+1]),
			.div_s2   (stg_div[k+1]),
			.rem_u_s2 (stg_rem_u[k+1]),
			.rem_v_s2 (stg_rem_v[k+1]),
			.q_u_s2   (stg_q_u[k+1]),
			.q_v_s2   (stg_q_v[k+1])
		);
	end

	// output stage
	cmfs_finish #(
		.UV_FRAC_BITS(UV_FRAC_BITS)
	) u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (stg_adv[NSTG-1]),
		.in_valid     (stg_valid[Q_W]),
		.in_ctl       (stg_ctl[Q_W]),
		.in_q_u       (stg_q_u[Q_W]),
		.in_q_v       (stg_q_v[Q_W]),
		.valid_s3     (stg_valid[NSTG-1]),
		.face_s3      (face),
		.tex_u_s3     (tex_u),
		.tex_v_s3     (tex_v),
		.vec_valid_s3 (vector_valid)
	);

	// output packing
	assign m_tvalid   = stg_valid[NSTG-1];
	assign m_tdata    = OUT_W'({tex_v, tex_u, face});
	assign m_tuser[0] = vector_valid;

	// zero vector always leaves as -x at the center
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> face == cmfs_pkg::FACE_NX && tex_u == HALF && tex_v == HALF)
		else $error("zero vector result wrong");

	// coordinates stay within [0, 1.0]
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tex_u <= ONE && tex_v <= ONE)
		else $error("coordinate out of range");

	// face code stays among the six faces
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> face <= cmfs_pkg::FACE_NZ)
		else $error("face code out of range");

	// input only backs up when the first stage holds a word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> stg_valid[0])
		else $error("input stalled with empty first stage");

	// a word taken at the output with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !stg_valid[Q_W] |=> !m_tvalid)
		else $error("output word repeated");

endmodule
